/* rtl/dssm_pkg.sv */
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and constants for the two-stack shared memory block.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DEPTH_DEFAULT = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath: take the request on the input ports this cycle.
  typedef struct packed {
    logic take;
  } dp_cmd_t;

endpackage

/* rtl/dual_stack_shared_memory.sv */
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two stacks in one word memory: lower grows up from word 0, upper grows down.
// ----------------------------------------------------------------------------
// Result: a request's result is valid in the cycle after the request is accepted
//   and is held until taken.
// Handshake: the controller holds the result register until it is taken and
//   accepts no new request meanwhile.
// Reset: rst (synchronous, active high) empties both stacks; memory words are
//   not cleared, and only words that were written are returned as results.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory #(
  parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dssm_pkg::CMD_W-1:0]          cmd,
  input  logic                               which_stack,
  input  logic signed [dssm_pkg::WORD_W-1:0]  push_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dssm_pkg::WORD_W-1:0]  read_value,
  output logic [dssm_pkg::STATUS_W-1:0]       status,
  output logic                               lower_empty,
  output logic                               upper_empty,
  output logic                               memory_full
);

  // Command from the controller: take the request this cycle.
  dssm_pkg::dp_cmd_t dp_cmd;

  // Controller: alternate between waiting for a request and holding a result.
  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  // Datapath: update counts, access the shared memory, register the result.
  dssm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .cmd         (cmd),
    .which_stack (which_stack),
    .push_value  (push_value),
    .read_value  (read_value),
    .status      (status),
    .lower_empty (lower_empty),
    .upper_empty (upper_empty),
    .memory_full (memory_full)
  );

endmodule

/* rtl/dssm_ctrl.sv */
// ----------------------------------------------------------------------------
// dssm_ctrl
// Handshake controller: accept one request, then present its result.
// ----------------------------------------------------------------------------
module dssm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dssm_pkg::dp_cmd_t dp_cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign dp_cmd.take = in_valid && (state == S_IDLE);

endmodule

/* rtl/dssm_dp.sv */
// ----------------------------------------------------------------------------
// dssm_dp
// Datapath: stack counts, shared word memory and result registers.
// ----------------------------------------------------------------------------
module dssm_dp #(
  parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dssm_pkg::dp_cmd_t                     dp_cmd,
  input  logic [dssm_pkg::CMD_W-1:0]            cmd,
  input  logic                                 which_stack,
  input  logic signed [dssm_pkg::WORD_W-1:0]    push_value,
  output logic signed [dssm_pkg::WORD_W-1:0]    read_value,
  output logic [dssm_pkg::STATUS_W-1:0]         status,
  output logic                                 lower_empty,
  output logic                                 upper_empty,
  output logic                                 memory_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_M1  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  logic [dssm_pkg::WORD_W-1:0] mem [DEPTH];

  logic [CW-1:0] lower_count;
  logic [CW-1:0] upper_count;
  logic [CW-1:0] lower_count_next;
  logic [CW-1:0] upper_count_next;

  logic [dssm_pkg::WORD_W-1:0] rd_q;
  logic                        res_from_mem;
  logic                        res_one;
  logic [dssm_pkg::STATUS_W-1:0] res_status;

  logic          is_push;
  logic          is_pop;
  logic          is_read;
  logic [CW:0]   count_sum;
  logic          full_now;
  logic [CW-1:0] sel_count;
  logic          sel_empty;
  logic          push_ok;
  logic          read_ok;
  logic [CW-1:0] wr_addr_w;
  logic [CW-1:0] rd_addr_w;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  always_comb begin
    is_push   = (cmd == dssm_pkg::CMD_PUSH);
    is_pop    = (cmd == dssm_pkg::CMD_POP);
    is_read   = is_pop || (cmd == dssm_pkg::CMD_PEEK);
    count_sum = {1'b0, lower_count} + {1'b0, upper_count};
    full_now  = (count_sum >= {1'b0, DEPTH_C});
    sel_count = which_stack ? upper_count : lower_count;
    sel_empty = (sel_count == '0);
    push_ok   = is_push && !full_now;
    read_ok   = is_read && !sel_empty;
    wr_addr_w = which_stack ? (DEPTH_M1 - upper_count) : lower_count;
    rd_addr_w = which_stack ? (DEPTH_C - upper_count) : (lower_count - ONE_C);
    wr_addr   = wr_addr_w[AW-1:0];
    rd_addr   = rd_addr_w[AW-1:0];

    lower_count_next = lower_count;
    upper_count_next = upper_count;
    if (push_ok) begin
      if (which_stack) begin
        upper_count_next = upper_count + ONE_C;
      end else begin
        lower_count_next = lower_count + ONE_C;
      end
    end else if (read_ok && is_pop) begin
      if (which_stack) begin
        upper_count_next = upper_count - ONE_C;
      end else begin
        lower_count_next = lower_count - ONE_C;
      end
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dp_cmd.take && push_ok) begin
      mem[wr_addr] <= push_value;
    end
    if (dp_cmd.take) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
    end else if (dp_cmd.take) begin
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.take) begin
      res_from_mem <= read_ok;
      res_one      <= is_read && sel_empty;
      if (is_push && full_now) begin
        res_status <= dssm_pkg::ST_FULL;
      end else if (is_read && sel_empty) begin
        res_status <= dssm_pkg::ST_EMPTY;
      end else begin
        res_status <= dssm_pkg::ST_OK;
      end
    end
  end

  assign read_value  = res_from_mem ? rd_q : {{(dssm_pkg::WORD_W-1){1'b0}}, res_one};
  assign status      = res_status;
  assign lower_empty = (lower_count == '0);
  assign upper_empty = (upper_count == '0);
  assign memory_full = full_now;

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count_sum <= {1'b0, DEPTH_C})
    else $error("stack counts exceed memory depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.take && is_push && full_now |=> $stable(lower_count) && $stable(upper_count))
    else $error("refused push changed a count");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.take && is_read && sel_empty |=> $stable(lower_count) && $stable(upper_count))
    else $error("pop on empty stack changed a count");

endmodule
